>>> src/assert_macros.svh
// Assertion macros shared by the flash protect event logger modules.
// Each user module must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FPEL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fpel assertion failed");
`define FPEL_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
`else
`define FPEL_ASSERT(lbl, prop)
`define FPEL_ASSERT_MSG(lbl, prop, msg)
`endif
`endif

>>> src/fpel_pkg.sv
// Package for the flash protect event logger: event codes, log entry,
// result and control/status types, flag decode. No dependencies.
`timescale 1ns / 1ps

package fpel_pkg;

  localparam int unsigned LOG_DEPTH_DEF = 256;
  localparam int unsigned PENDING_W     = 9;
  localparam int unsigned FLAGS_W       = 6;
  localparam int unsigned CYC_W         = 3;
  localparam int unsigned CYC_LSB       = 17;

  localparam logic [31:0] REGION_BASE_RST = 32'hFF00_0000;

  localparam logic [FLAGS_W-1:0] EV_WREN    = 6'h01;
  localparam logic [FLAGS_W-1:0] EV_LOCKOFF = 6'h02;
  localparam logic [FLAGS_W-1:0] EV_WRITE   = 6'h04;
  localparam logic [FLAGS_W-1:0] EV_ERASE   = 6'h08;
  localparam logic [FLAGS_W-1:0] EV_SMMOFF  = 6'h10;
  localparam logic [FLAGS_W-1:0] EV_REGION  = 6'h20;

  localparam logic [CYC_W-1:0] CYC_WRITE = 3'd2;
  localparam logic [CYC_W-1:0] CYC_ERASE = 3'd3;

  localparam int unsigned BIOS_WREN_BIT = 0;
  localparam int unsigned BIOS_LOCK_BIT = 1;
  localparam int unsigned BIOS_SMM_BIT  = 5;

  typedef enum logic {
    OP_CHECK = 1'b0,
    OP_POP   = 1'b1
  } fpel_op_t;

  typedef struct packed {
    logic [63:0]        stamp;
    logic [FLAGS_W-1:0] flags;
    logic [7:0]         bios;
    logic [31:0]        status;
    logic [31:0]        addr;
  } fpel_entry_t;

  typedef struct packed {
    logic                 issue;
    logic [FLAGS_W-1:0]   event_bits;
    logic                 recorded;
    logic                 dropped_oldest;
    logic                 pop_valid;
    logic [63:0]          stamp;
    logic [7:0]           snap_bios;
    logic [31:0]          snap_status;
    logic [31:0]          snap_addr;
    logic [CYC_W-1:0]     snap_cycle;
    logic [PENDING_W-1:0] pending;
  } fpel_res_t;

  typedef struct packed {
    logic accept;  // latch request, start log read
    logic commit;  // update log and load result register
  } fpel_cmd_t;

  typedef struct packed {
    logic out_full;
  } fpel_sts_t;

  function automatic logic [FLAGS_W-1:0] fpel_flags(input logic [7:0]  bios,
                                                    input logic [31:0] fst,
                                                    input logic [31:0] addr,
                                                    input logic [31:0] base);
    logic [FLAGS_W-1:0] f;
    logic [CYC_W-1:0]   cyc;
    cyc = fst[CYC_LSB +: CYC_W];
    f   = '0;
    if (bios[BIOS_WREN_BIT])  f = f | EV_WREN;
    if (!bios[BIOS_LOCK_BIT]) f = f | EV_LOCKOFF;
    if (!bios[BIOS_SMM_BIT])  f = f | EV_SMMOFF;
    if (cyc == CYC_WRITE)     f = f | EV_WRITE;
    if (cyc == CYC_ERASE)     f = f | EV_ERASE;
    if (addr >= base)         f = f | EV_REGION;
    return f;
  endfunction

endpackage

>>> src/fpel_ctrl.sv
// Controller for the flash protect event logger: two-state sequencer that
// accepts one request, then commits it once the result register is free.
// Depends on fpel_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fpel_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                out_stall,
  input  fpel_pkg::fpel_sts_t sts,
  output fpel_pkg::fpel_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd.accept = (state_r == S_IDLE) && in_valid;
    cmd.commit = (state_r == S_EXEC) && (!sts.out_full || !out_stall);
    in_stall   = (state_r != S_IDLE);
    state_nxt  = state_r;
    unique case (state_r)
      S_IDLE: if (cmd.accept) state_nxt = S_EXEC;
      S_EXEC: if (cmd.commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `FPEL_ASSERT(a_accept_then_exec, cmd.accept |=> (state_r == S_EXEC))
  `FPEL_ASSERT(a_commit_then_idle, cmd.commit |=> (state_r == S_IDLE))
  `FPEL_ASSERT_MSG(a_hold_when_blocked,
    (state_r == S_EXEC && sts.out_full && out_stall) |=> (state_r == S_EXEC),
    "request committed while result register blocked")

endmodule

>>> src/fpel_dp.sv
// Datapath for the flash protect event logger: request registers, flag
// decode, event log memory with pointers and count, result register.
// Depends on fpel_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fpel_dp #(
  parameter int unsigned LOG_DEPTH = fpel_pkg::LOG_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fpel_pkg::fpel_cmd_t cmd,
  output fpel_pkg::fpel_sts_t sts,
  input  logic                in_operation,
  input  logic [7:0]          in_bios_status,
  input  logic [31:0]         in_flash_status,
  input  logic [31:0]         in_flash_address,
  input  logic [63:0]         in_stamp_in,
  input  logic                cfg_valid,
  input  logic [31:0]         cfg_data,
  input  logic                out_stall,
  output logic                out_valid,
  output fpel_pkg::fpel_res_t res
);

  localparam int unsigned PTR_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(LOG_DEPTH + 1);

  fpel_pkg::fpel_op_t op_r;
  logic [7:0]         bios_r;
  logic [31:0]        fst_r;
  logic [31:0]        addr_r;
  logic [63:0]        stamp_r;
  logic [31:0]        base_r;

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  fpel_pkg::fpel_entry_t log_mem [LOG_DEPTH];
  fpel_pkg::fpel_entry_t rd_data_r;
  fpel_pkg::fpel_entry_t wr_entry;
  logic                  wr_en;

  fpel_pkg::fpel_res_t res_r, res_nxt;
  logic                out_valid_r;

  logic [fpel_pkg::FLAGS_W-1:0] flags;
  logic                         has_flag;
  logic                         full;
  logic                         not_empty;

  function automatic logic [PTR_W-1:0] nxt_slot(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(LOG_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r    <= fpel_pkg::fpel_op_t'(in_operation);
      bios_r  <= in_bios_status;
      fst_r   <= in_flash_status;
      addr_r  <= in_flash_address;
      stamp_r <= in_stamp_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= fpel_pkg::REGION_BASE_RST;
    end else if (cfg_valid) begin
      base_r <= cfg_data;
    end
  end

  always_comb begin
    flags     = fpel_pkg::fpel_flags(bios_r, fst_r, addr_r, base_r);
    has_flag  = |flags;
    full      = (cnt_r == CNT_W'(LOG_DEPTH));
    not_empty = (cnt_r != '0);

    wr_entry.stamp  = stamp_r;
    wr_entry.flags  = flags;
    wr_entry.bios   = bios_r;
    wr_entry.status = fst_r;
    wr_entry.addr   = addr_r;

    wr_en      = 1'b0;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    res_nxt    = '0;

    if (cmd.commit) begin
      if (op_r == fpel_pkg::OP_CHECK) begin
        res_nxt.issue      = |(flags & ~fpel_pkg::EV_REGION);
        res_nxt.event_bits = flags;
        if (has_flag) begin
          wr_en            = 1'b1;
          wr_ptr_nxt       = nxt_slot(wr_ptr_r);
          res_nxt.recorded = 1'b1;
          if (full) begin
            // overwrite oldest: drop it from the read side, count stays
            rd_ptr_nxt             = nxt_slot(rd_ptr_r);
            res_nxt.dropped_oldest = 1'b1;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
      end else if (not_empty) begin
        res_nxt.pop_valid   = 1'b1;
        res_nxt.event_bits  = rd_data_r.flags;
        res_nxt.stamp       = rd_data_r.stamp;
        res_nxt.snap_bios   = rd_data_r.bios;
        res_nxt.snap_status = rd_data_r.status;
        res_nxt.snap_addr   = rd_data_r.addr;
        res_nxt.snap_cycle  = rd_data_r.status[fpel_pkg::CYC_LSB +: fpel_pkg::CYC_W];
        rd_ptr_nxt          = nxt_slot(rd_ptr_r);
        cnt_nxt             = cnt_r - CNT_W'(1);
      end
    end
    res_nxt.pending = fpel_pkg::PENDING_W'(cnt_nxt);
  end

  // log memory: read issued at accept, so data is ready by commit
  always_ff @(posedge clk) begin
    if (wr_en) begin
      log_mem[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_data_r <= log_mem[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_r <= res_nxt;
    end
  end

  assign sts.out_full = out_valid_r;
  assign out_valid    = out_valid_r;
  assign res          = res_r;

  `FPEL_ASSERT_MSG(a_cnt_bound, cnt_r <= CNT_W'(LOG_DEPTH), "log count overflow")
  `FPEL_ASSERT(a_ptr_match_edge,
    (cnt_r == '0 || cnt_r == CNT_W'(LOG_DEPTH)) |-> (wr_ptr_r == rd_ptr_r))
  `FPEL_ASSERT(a_pop_dec,
    (cmd.commit && op_r == fpel_pkg::OP_POP && not_empty)
      |=> (cnt_r == $past(cnt_r) - CNT_W'(1)))

endmodule

>>> src/flash_protect_event_logger_top.sv
// Flash protect event logger, top level.
// Channels: in_* request (check a register sample or pop the oldest event),
// out_* one result per request, cfg_* write of the BIOS region base.
// Each request enters on in_valid with in_stall low. The sequencer takes one
// request, commits it from its exec state once the result register is free
// and shows it on out_valid from the registered valid flag; it takes no new
// request until that commit. The exec state covers the log memory read,
// issued when the request is taken and used at commit.
// A finished result sits in the output register; while out_stall is high
// the next request is still taken, then held at commit until the register
// frees, and in_stall stays high meanwhile.
// Reset (rst_n low, synchronous) empties the log (pointers and count to
// zero) and sets the region base to 0xFF000000; log contents are not
// cleared, a pop only reads written entries. cfg_ready is always high;
// write the base only while no request is in flight.
// Depends on fpel_pkg, fpel_ctrl, fpel_dp.
`timescale 1ns / 1ps

module flash_protect_event_logger_top #(
  parameter int unsigned LOG_DEPTH = fpel_pkg::LOG_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [7:0]  in_bios_status,
  input  logic [31:0] in_flash_status,
  input  logic [31:0] in_flash_address,
  input  logic [63:0] in_stamp_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_issue,
  output logic [5:0]  out_event_bits,
  output logic        out_recorded,
  output logic        out_dropped_oldest,
  output logic        out_pop_valid,
  output logic [63:0] out_stamp,
  output logic [7:0]  out_snap_bios,
  output logic [31:0] out_snap_status,
  output logic [31:0] out_snap_addr,
  output logic [2:0]  out_snap_cycle,
  output logic [8:0]  out_pending,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  fpel_pkg::fpel_cmd_t cmd;
  fpel_pkg::fpel_sts_t sts;
  fpel_pkg::fpel_res_t res;

  fpel_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  fpel_dp #(
    .LOG_DEPTH (LOG_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_operation     (in_operation),
    .in_bios_status   (in_bios_status),
    .in_flash_status  (in_flash_status),
    .in_flash_address (in_flash_address),
    .in_stamp_in      (in_stamp_in),
    .cfg_valid        (cfg_valid),
    .cfg_data         (cfg_data),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .res              (res)
  );

  assign cfg_ready          = 1'b1;
  assign out_issue          = res.issue;
  assign out_event_bits     = res.event_bits;
  assign out_recorded       = res.recorded;
  assign out_dropped_oldest = res.dropped_oldest;
  assign out_pop_valid      = res.pop_valid;
  assign out_stamp          = res.stamp;
  assign out_snap_bios      = res.snap_bios;
  assign out_snap_status    = res.snap_status;
  assign out_snap_addr      = res.snap_addr;
  assign out_snap_cycle     = res.snap_cycle;
  assign out_pending        = res.pending;

endmodule

>>> verif/tb_top.sv
// Testbench for flash_protect_event_logger_top: flag decode, event ring
// logging/overwrite/pop and the region base register, against a local model.
// Depends on fpel_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_top;

  localparam int RING_DEPTH    = fpel_pkg::LOG_DEPTH_DEF;
  localparam int HOLD_CYCLES   = 200;
  localparam int SETTLE_CYCLES = 6;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_operation = 1'b0;
  logic [7:0]  in_bios_status = '0;
  logic [31:0] in_flash_status = '0;
  logic [31:0] in_flash_address = '0;
  logic [63:0] in_stamp_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_issue;
  logic [5:0]  out_event_bits;
  logic        out_recorded;
  logic        out_dropped_oldest;
  logic        out_pop_valid;
  logic [63:0] out_stamp;
  logic [7:0]  out_snap_bios;
  logic [31:0] out_snap_status;
  logic [31:0] out_snap_addr;
  logic [2:0]  out_snap_cycle;
  logic [8:0]  out_pending;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  flash_protect_event_logger_top i_dut (.*);

  always #5 clk = ~clk;

  // local model of the event ring
  typedef struct {
    logic [63:0] stamp;
    logic [5:0]  flags;
    logic [7:0]  bios;
    logic [31:0] status;
    logic [31:0] addr;
    logic [2:0]  cycle;
  } log_slot_t;

  log_slot_t   ring_slots[RING_DEPTH];
  int          ring_head = 0;   // oldest held entry
  int          ring_tail = 0;   // next slot to write
  int          ring_fill = 0;
  logic [31:0] region_base = fpel_pkg::REGION_BASE_RST;

  fpel_pkg::fpel_res_t awaited_replies[$];
  fpel_pkg::fpel_res_t head_reply;

  int error_count = 0;
  int n_checks = 0, n_logged = 0, n_overwrites = 0;
  int n_pops = 0, n_empty_pops = 0, n_bases = 0;

  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;
  int hold_left = 0;
  int stretch_left = 0;

  function automatic fpel_pkg::fpel_res_t predict_logger_reply(
      input fpel_pkg::fpel_op_t op,
      input logic [7:0] bios,
      input logic [31:0] fst,
      input logic [31:0] addr,
      input logic [63:0] stamp);
    fpel_pkg::fpel_res_t r;
    log_slot_t           slot;
    logic [5:0]          flags;
    logic [2:0]          cyc;
    r = '0;
    if (op == fpel_pkg::OP_CHECK) begin
      n_checks++;
      cyc   = fst[fpel_pkg::CYC_LSB +: fpel_pkg::CYC_W];
      flags = {addr >= region_base, ~bios[5], cyc == fpel_pkg::CYC_ERASE,
               cyc == fpel_pkg::CYC_WRITE, ~bios[1], bios[0]};
      r.issue      = |flags[4:0];
      r.event_bits = flags;
      if (flags != '0) begin
        if (ring_fill == RING_DEPTH) begin
          ring_head = (ring_head + 1) % RING_DEPTH;
          ring_fill--;
          r.dropped_oldest = 1'b1;
          n_overwrites++;
        end
        ring_slots[ring_tail] = '{stamp, flags, bios, fst, addr, cyc};
        ring_tail  = (ring_tail + 1) % RING_DEPTH;
        ring_fill++;
        r.recorded = 1'b1;
        n_logged++;
      end
    end else begin
      n_pops++;
      if (ring_fill > 0) begin
        slot          = ring_slots[ring_head];
        r.event_bits  = slot.flags;
        r.pop_valid   = 1'b1;
        r.stamp       = slot.stamp;
        r.snap_bios   = slot.bios;
        r.snap_status = slot.status;
        r.snap_addr   = slot.addr;
        r.snap_cycle  = slot.cycle;
        ring_head     = (ring_head + 1) % RING_DEPTH;
        ring_fill--;
      end else begin
        n_empty_pops++;
      end
    end
    r.pending = fpel_pkg::PENDING_W'(ring_fill);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_replies.size() == 0) begin
        $error("result with no request outstanding");
        error_count++;
      end else begin
        head_reply = awaited_replies.pop_front();
        check_field("issue", 64'(head_reply.issue), 64'(out_issue));
        check_field("event_bits", 64'(head_reply.event_bits), 64'(out_event_bits));
        check_field("recorded", 64'(head_reply.recorded), 64'(out_recorded));
        check_field("dropped_oldest", 64'(head_reply.dropped_oldest),
                    64'(out_dropped_oldest));
        check_field("pop_valid", 64'(head_reply.pop_valid), 64'(out_pop_valid));
        check_field("stamp", head_reply.stamp, out_stamp);
        check_field("snap_bios", 64'(head_reply.snap_bios), 64'(out_snap_bios));
        check_field("snap_status", 64'(head_reply.snap_status), 64'(out_snap_status));
        check_field("snap_addr", 64'(head_reply.snap_addr), 64'(out_snap_addr));
        check_field("snap_cycle", 64'(head_reply.snap_cycle), 64'(out_snap_cycle));
        check_field("pending", 64'(head_reply.pending), 64'(out_pending));
      end
    end
  end

  // result side stall: random stretches, or a long hold when requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!stalls_on) begin
      out_stall <= 1'b0;
    end else if (stretch_left > 0) begin
      stretch_left <= stretch_left - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      out_stall    <= 1'b1;
      stretch_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                   : $urandom_range(0, 2);
    end else begin
      out_stall    <= 1'b0;
      stretch_left <= $urandom_range(0, 30);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_request(input fpel_pkg::fpel_op_t op, input logic [7:0] bios,
                              input logic [31:0] fst, input logic [31:0] addr,
                              input logic [63:0] stamp);
    int gap;
    in_valid         <= 1'b1;
    in_operation     <= op;
    in_bios_status   <= bios;
    in_flash_status  <= fst;
    in_flash_address <= addr;
    in_stamp_in      <= stamp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    awaited_replies.push_back(predict_logger_reply(op, bios, fst, addr, stamp));
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_check(input logic [7:0] bios, input logic [31:0] fst,
                            input logic [31:0] addr);
    send_request(fpel_pkg::OP_CHECK, bios, fst, addr, {$urandom, $urandom});
  endtask

  // sample fields are don't-care on a pop, so fill them with noise
  task automatic send_pop();
    send_request(fpel_pkg::OP_POP, 8'($urandom), $urandom, $urandom,
                 {$urandom, $urandom});
  endtask

  task automatic send_random_check();
    logic [7:0]  bios;
    logic [31:0] fst;
    logic [31:0] addr;
    bios = 8'($urandom);
    if ($urandom_range(0, 1)) bios = (bios & 8'hDC) | 8'h22;  // protections mostly on
    fst = $urandom;
    if ($urandom_range(0, 1)) begin
      fst[fpel_pkg::CYC_LSB +: fpel_pkg::CYC_W] = 3'($urandom_range(0, 3));
    end
    case ($urandom_range(0, 5))
      0: addr = region_base;
      1: addr = region_base - 1;
      2: addr = region_base + 1;
      3: addr = '0;
      4: addr = '1;
      default: addr = $urandom;
    endcase
    send_check(bios, fst, addr);
  endtask

  task automatic drain_replies();
    in_valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_region_base(input logic [31:0] base);
    drain_replies();
    cfg_valid <= 1'b1;
    cfg_data  <= base;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid   <= 1'b0;
    region_base  = base;
    n_bases++;
  endtask

  task automatic test_flag_decode();
    write_region_base(fpel_pkg::REGION_BASE_RST);
    send_request(fpel_pkg::OP_CHECK, 8'h22, '0, '0, '0);           // nothing to flag
    send_request(fpel_pkg::OP_CHECK, 8'h22, '0, 32'hFF00_0000, '1); // region flag alone
    send_check(8'h22, '0, 32'hFEFF_FFFF);
    send_check(8'h22, '0, 32'hFFFF_FFFF);
    send_check(8'h23, '0, '0);
    send_check(8'h20, '0, '0);
    send_check(8'h02, '0, '0);
    send_check(8'hFF, '0, '0);
    for (int c = 0; c < 8; c++) send_check(8'h22, 32'(c) << fpel_pkg::CYC_LSB, '0);
    send_check(8'h22, 32'hFFF5_FFFF, 32'h1234_5678);     // write cycle, noisy status
    while (ring_fill > 0) send_pop();
    send_pop();
    send_pop();
  endtask

  task automatic test_ring_wrap();
    write_region_base('0);  // every check gets logged
    repeat (RING_DEPTH + 6) send_random_check();
    repeat (RING_DEPTH + 2) send_pop();
  endtask

  task automatic test_backpressure();
    write_region_base(32'h8000_0000);
    gaps_on   = 1'b0;
    hold_left = HOLD_CYCLES;
    repeat (12) send_random_check();
    gaps_on = 1'b1;
    drain_replies();
  endtask

  task automatic test_random_traffic();
    int pop_pct;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_region_base(32'hFFFF_FFFF);
        1: write_region_base('0);
        2: write_region_base(fpel_pkg::REGION_BASE_RST);
        default: write_region_base($urandom);
      endcase
      gaps_on   = (phase != 0);
      stalls_on = (phase != 0);
      pop_pct   = (phase % 3 == 0) ? 15 : (phase % 3 == 1) ? 50 : 80;
      repeat ($urandom_range(60, 80)) begin
        if ($urandom_range(0, 99) < pop_pct) send_pop();
        else send_random_check();
      end
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_flag_decode();
    test_ring_wrap();
    test_backpressure();
    test_random_traffic();
    drain_replies();
    $display("Covered %0d checks (%0d logged, %0d overwrote the oldest entry)",
             n_checks, n_logged, n_overwrites);
    $display("and %0d pops (%0d on an empty ring) over %0d region base settings",
             n_pops, n_empty_pops, n_bases);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
